// ===== hdl/mdpf_pkg.sv =====
package mdpf_pkg;

  localparam int DEF_GRID_ROWS   = 16;
  localparam int DEF_GRID_COLS   = 32;
  localparam int DEF_STACK_DEPTH = 512;

  localparam int OP_W      = 2;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 5;
  localparam int DIR_W     = 3;
  localparam int IDX_W     = 9;
  localparam int PLEN_W    = 10;
  localparam int ENTRY_W   = ROW_W + COL_W + DIR_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  localparam logic [ROW_W-1:0] RST_START_ROW = 4'd1;
  localparam logic [COL_W-1:0] RST_START_COL = 5'd1;
  localparam logic [ROW_W-1:0] RST_EXIT_ROW  = 4'd10;
  localparam logic [COL_W-1:0] RST_EXIT_COL  = 5'd8;

  localparam logic [DIR_W-1:0] DIR_COL_INC = 3'd0;
  localparam logic [DIR_W-1:0] DIR_ROW_INC = 3'd1;
  localparam logic [DIR_W-1:0] DIR_COL_DEC = 3'd2;
  localparam logic [DIR_W-1:0] DIR_ROW_DEC = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE    = 3'd4;

  typedef enum logic [1:0] {
    REG_START_ROW = 2'd0,
    REG_START_COL = 2'd1,
    REG_EXIT_ROW  = 2'd2,
    REG_EXIT_COL  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_CLR,
    ST_PROBE,
    ST_TEST,
    ST_POP
  } state_t;

endpackage

// ===== hdl/maze_dfs_path_finder.sv =====
// Channel | Dir | Fields (low bit up)                                          | Item
// in_     | in  | tuser: op[1:0]; tdata: row[3:0] col[8:4] wall[9]              | command
//         |     |   entry_index[18:10]                                          |
// out_    | out | found[0] path_length[10:1] step_row[14:11] step_col[19:15]  | status
//         |     | step_dir[22:20]                                             |
// cfg_    | in  | APB: start_row 0x0, start_col 0x4, exit_row 0x8, exit_col 0xC | register
//
// Load and unused op answer from the idle state; read passes through the read state
// (stack RAM read latency). Search sweeps the visited RAM, then settles each direction
// tried in the probe state (exit hit or off grid) or via the test state (wall/visited
// RAM read); each pop passes through the pop state. After reset the wall and visited
// RAMs are swept to zero, in_tready low meanwhile. in_tready stays low while a search
// or read runs. A held result does not block the next item once out_tready is high.
module maze_dfs_path_finder #(
  parameter int GRID_ROWS   = mdpf_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS   = mdpf_pkg::DEF_GRID_COLS,
  parameter int STACK_DEPTH = mdpf_pkg::DEF_STACK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // op
  input  logic [mdpf_pkg::OP_W-1:0]        in_tuser,
  // row, col, wall, entry_index
  input  logic [mdpf_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // found, path_length, step_row, step_col, step_dir
  output logic [mdpf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mdpf_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [mdpf_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [mdpf_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  import mdpf_pkg::*;

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int CAW   = $clog2(CELLS);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int RES_W = 1 + PLEN_W + ROW_W + COL_W + DIR_W;

  state_t state_r, state_nxt;

  logic [ROW_W-1:0] start_row_r, start_row_nxt;
  logic [COL_W-1:0] start_col_r, start_col_nxt;
  logic [ROW_W-1:0] exit_row_r, exit_row_nxt;
  logic [COL_W-1:0] exit_col_r, exit_col_nxt;

  logic [ROW_W-1:0] cur_r_r, cur_r_nxt;
  logic [COL_W-1:0] cur_c_r, cur_c_nxt;
  logic [DIR_W-1:0] cur_d_r, cur_d_nxt;
  logic [SPW-1:0]   sp_r, sp_nxt;
  logic             found_r, found_nxt;
  logic [CAW-1:0]   cnt_r, cnt_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [RES_W-1:0] out_data_r, out_data_nxt;

  logic [1:0]       in_op;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_wall;
  logic [IDX_W-1:0] in_idx;
  logic             in_acc;
  logic             in_on_grid;

  logic [ROW_W:0]   nb_r;
  logic [COL_W:0]   nb_c;
  logic             nb_neg;
  logic             nb_on_grid;
  logic             nb_exit;
  logic [CAW-1:0]   nb_addr;
  logic [SPW-1:0]   sp_dec;
  logic             stk_full;

  logic             wall_we, wall_wd, wall_rd;
  logic [CAW-1:0]   wall_wa;
  logic             vis_we, vis_wd, vis_rd;
  logic [CAW-1:0]   vis_wa;
  logic             stk_we;
  logic [SAW-1:0]   stk_wa, stk_ra;
  logic [ENTRY_W-1:0] stk_wd, stk_rd;

  logic             out_load;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  logic [DIR_W-1:0] res_dir;
  logic             cfg_wr;

  assign in_op   = in_tuser;
  assign in_row  = in_tdata[3:0];
  assign in_col  = in_tdata[8:4];
  assign in_wall = in_tdata[9];
  assign in_idx  = in_tdata[18:10];

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign in_on_grid = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_data_r};

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_START_ROW: cfg_prdata = CFG_DW'(start_row_r);
      REG_START_COL: cfg_prdata = CFG_DW'(start_col_r);
      REG_EXIT_ROW:  cfg_prdata = CFG_DW'(exit_row_r);
      REG_EXIT_COL:  cfg_prdata = CFG_DW'(exit_col_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_comb begin
    start_row_nxt = start_row_r;
    start_col_nxt = start_col_r;
    exit_row_nxt  = exit_row_r;
    exit_col_nxt  = exit_col_r;
    if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_START_ROW: start_row_nxt = cfg_pwdata[ROW_W-1:0];
        REG_START_COL: start_col_nxt = cfg_pwdata[COL_W-1:0];
        REG_EXIT_ROW:  exit_row_nxt  = cfg_pwdata[ROW_W-1:0];
        REG_EXIT_COL:  exit_col_nxt  = cfg_pwdata[COL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // neighbor of the current cell in the current direction; a step below zero wraps high
  always_comb begin
    nb_r   = {1'b0, cur_r_r};
    nb_c   = {1'b0, cur_c_r};
    nb_neg = 1'b0;
    case (cur_d_r)
      DIR_COL_INC: nb_c = {1'b0, cur_c_r} + (COL_W+1)'(1);
      DIR_ROW_INC: nb_r = {1'b0, cur_r_r} + (ROW_W+1)'(1);
      DIR_COL_DEC: begin
        nb_c   = {1'b0, cur_c_r} - (COL_W+1)'(1);
        nb_neg = (cur_c_r == '0);
      end
      DIR_ROW_DEC: begin
        nb_r   = {1'b0, cur_r_r} - (ROW_W+1)'(1);
        nb_neg = (cur_r_r == '0);
      end
      default: begin
      end
    endcase
  end

  assign nb_exit    = (nb_r == {1'b0, exit_row_r}) && (nb_c == {1'b0, exit_col_r});
  assign nb_on_grid = !nb_neg && (32'(nb_r) < GRID_ROWS) && (32'(nb_c) < GRID_COLS);
  assign nb_addr    = CAW'((32'(nb_r) * GRID_COLS) + 32'(nb_c));
  assign sp_dec     = sp_r - SPW'(1);
  assign stk_full   = (sp_r == SPW'(STACK_DEPTH));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (cnt_r == CAW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_op))
            OP_SEARCH: state_nxt = ST_CLR;
            OP_READ:   state_nxt = ST_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD: state_nxt = ST_IDLE;
      ST_CLR: begin
        if (cnt_r == CAW'(CELLS - 1)) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (cur_d_r == DIR_DONE) begin
          state_nxt = (sp_r == '0) ? ST_IDLE : ST_POP;
        end else if (nb_exit) begin
          state_nxt = ST_IDLE;
        end else if (nb_on_grid) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (!wall_rd && !vis_rd && stk_full) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_POP:  state_nxt = ST_PROBE;
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cur_r_nxt     = cur_r_r;
    cur_c_nxt     = cur_c_r;
    cur_d_nxt     = cur_d_r;
    sp_nxt        = sp_r;
    found_nxt     = found_r;
    cnt_nxt       = cnt_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_load      = 1'b0;
    res_row       = '0;
    res_col       = '0;
    res_dir       = '0;
    wall_we       = 1'b0;
    wall_wa       = cnt_r;
    wall_wd       = 1'b0;
    vis_we        = 1'b0;
    vis_wa        = cnt_r;
    vis_wd        = 1'b0;
    stk_we        = 1'b0;
    stk_wa        = sp_r[SAW-1:0];
    stk_wd        = {cur_d_r + DIR_W'(1), cur_c_r, cur_r_r};
    stk_ra        = sp_dec[SAW-1:0];
    case (state_r)
      ST_INIT: begin
        wall_we = 1'b1;
        vis_we  = 1'b1;
        cnt_nxt = cnt_r + CAW'(1);
      end
      ST_IDLE: begin
        stk_ra    = SAW'(in_idx);
        rd_ok_nxt = (32'(in_idx) < 32'(sp_r)) && (32'(in_idx) < STACK_DEPTH);
        cnt_nxt   = '0;
        if (in_acc) begin
          case (op_t'(in_op))
            OP_LOAD: begin
              wall_we  = in_on_grid;
              wall_wa  = CAW'((32'(in_row) * GRID_COLS) + 32'(in_col));
              wall_wd  = in_wall;
              out_load = 1'b1;
            end
            OP_SEARCH: begin
              cur_r_nxt = start_row_r;
              cur_c_nxt = start_col_r;
              cur_d_nxt = DIR_COL_INC;
              sp_nxt    = '0;
              found_nxt = 1'b0;
            end
            OP_READ: begin
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_RD: begin
        out_load = 1'b1;
        if (rd_ok_r) begin
          {res_dir, res_col, res_row} = stk_rd;
        end
      end
      ST_CLR: begin
        vis_we  = 1'b1;
        cnt_nxt = cnt_r + CAW'(1);
      end
      ST_PROBE: begin
        if (cur_d_r == DIR_DONE) begin
          if (sp_r == '0) begin
            out_load = 1'b1;
          end else begin
            sp_nxt = sp_dec;
          end
        end else if (nb_exit) begin
          out_load = 1'b1;
          if (stk_full) begin
            sp_nxt = '0;
          end else begin
            stk_we    = 1'b1;
            stk_wd    = {cur_d_r, nb_c[COL_W-1:0], nb_r[ROW_W-1:0]};
            sp_nxt    = sp_r + SPW'(1);
            found_nxt = 1'b1;
          end
        end else if (!nb_on_grid) begin
          cur_d_nxt = cur_d_r + DIR_W'(1);
        end
      end
      ST_TEST: begin
        if (!wall_rd && !vis_rd) begin
          if (stk_full) begin
            sp_nxt   = '0;
            out_load = 1'b1;
          end else begin
            stk_we    = 1'b1;
            sp_nxt    = sp_r + SPW'(1);
            vis_we    = 1'b1;
            vis_wa    = nb_addr;
            vis_wd    = 1'b1;
            cur_r_nxt = nb_r[ROW_W-1:0];
            cur_c_nxt = nb_c[COL_W-1:0];
            cur_d_nxt = DIR_COL_INC;
          end
        end else begin
          cur_d_nxt = cur_d_r + DIR_W'(1);
        end
      end
      ST_POP: begin
        {cur_d_nxt, cur_c_nxt, cur_r_nxt} = stk_rd;
      end
      default: begin
      end
    endcase
    out_data_nxt = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {res_dir, res_col, res_row, PLEN_W'(sp_nxt), found_nxt};
    end
  end

  mdpf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (wall_wa),
    .wdata (wall_wd),
    .raddr (nb_addr),
    .rdata (wall_rd)
  );

  mdpf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_wa),
    .wdata (vis_wd),
    .raddr (nb_addr),
    .rdata (vis_rd)
  );

  mdpf_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_wa),
    .wdata (stk_wd),
    .raddr (stk_ra),
    .rdata (stk_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      start_row_r <= RST_START_ROW;
      start_col_r <= RST_START_COL;
      exit_row_r  <= RST_EXIT_ROW;
      exit_col_r  <= RST_EXIT_COL;
      sp_r        <= '0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_row_r <= start_row_nxt;
      start_col_r <= start_col_nxt;
      exit_row_r  <= exit_row_nxt;
      exit_col_r  <= exit_col_nxt;
      sp_r        <= sp_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r_r    <= cur_r_nxt;
    cur_c_r    <= cur_c_nxt;
    cur_d_r    <= cur_d_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/mdpf_ram.sv =====
module mdpf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mdpf_chk.sv =====
module mdpf_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  // op
  input logic [mdpf_pkg::OP_W-1:0]        in_tuser,
  // row, col, wall, entry_index
  input logic [mdpf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  // found, path_length, step_row, step_col, step_dir
  input logic [mdpf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic [mdpf_pkg::CFG_AW-1:0]      cfg_paddr,
  input logic [mdpf_pkg::CFG_DW-1:0]      cfg_pwdata,
  input logic [mdpf_pkg::CFG_DW-1:0]      cfg_prdata,
  input logic                            cfg_pready
);

  import mdpf_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_tuser, in_tdata, cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr,
                       cfg_pwdata, cfg_prdata, cfg_pready};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_item_answered: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid || !in_tready)
    else $error("accepted item neither answered nor holding the input");

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[10:1] == '0)
    else $error("path length nonzero without a found path");

  a_empty_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:1] == '0 |-> out_tdata[22:11] == '0)
    else $error("step fields set with an empty path");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:20] <= DIR_DONE)
    else $error("step direction out of range");

endmodule

bind maze_dfs_path_finder mdpf_chk u_mdpf_chk (.*);
